>>> src/sequence_reorder_buffer_unit_defines.svh
// ----------------------------------------------------------------------------
// Reorder buffer assertion macros
// Concurrent check wrappers; compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef SEQUENCE_REORDER_BUFFER_UNIT_DEFINES_SVH
`define SEQUENCE_REORDER_BUFFER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define SRU_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define SRU_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define SRU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define SRU_ASSERT(lbl, cond, msg)
`define SRU_ASSERT_IMPL(lbl, ante, cons, msg)
`define SRU_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> src/sru_pkg.sv
// ----------------------------------------------------------------------------
// Reorder buffer package
// Shared constants, codes and the per-cell control struct.
// ----------------------------------------------------------------------------
`default_nettype none

package sru_pkg;

  localparam int DEPTH_DEF         = 16;
  localparam int PAYLOAD_BYTES_DEF = 8;

  localparam int SEQ_W   = 32;
  localparam int PORT_PW = 64;  // payload width on the ports
  localparam int FILL_W  = 5;
  localparam int CAP_W   = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_PULL   = 1'b1;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_READY = 2'd2
  } status_t;

  // broadcast to every cell each cycle
  typedef struct packed {
    logic ins;   // insert that is carried out
    logic pull;  // pull that is carried out
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> src/sru_cell.sv
// ----------------------------------------------------------------------------
// Reorder buffer cell
// One sorted slot: compares against the new number and shifts with neighbors.
// ----------------------------------------------------------------------------
`default_nettype none

module sru_cell
  import sru_pkg::*;
#(
  parameter int PAY_W = PAYLOAD_BYTES_DEF * 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cell_ctl_t        ctl,
  input  wire logic [SEQ_W-1:0] new_seq,
  input  wire logic [PAY_W-1:0] new_pay,
  input  wire logic             left_lt,
  input  wire logic             left_valid,
  input  wire logic [SEQ_W-1:0] left_seq,
  input  wire logic [PAY_W-1:0] left_pay,
  input  wire logic             right_valid,
  input  wire logic [SEQ_W-1:0] right_seq,
  input  wire logic [PAY_W-1:0] right_pay,
  output logic                  lt_o,
  output logic                  valid_o,
  output logic [SEQ_W-1:0]      seq_o,
  output logic [PAY_W-1:0]      pay_o
);

  logic             valid_r, valid_nxt;
  logic [SEQ_W-1:0] seq_r, seq_nxt;
  logic [PAY_W-1:0] pay_r, pay_nxt;

  // slot holds a number below the new one: it stays put on insert
  assign lt_o = valid_r && (seq_r < new_seq);

  always_comb begin
    valid_nxt = valid_r;
    seq_nxt   = seq_r;
    pay_nxt   = pay_r;
    if (ctl.ins) begin
      valid_nxt = valid_r | left_valid;
      if (!lt_o) begin
        if (left_lt) begin
          seq_nxt = new_seq;
          pay_nxt = new_pay;
        end else begin
          seq_nxt = left_seq;
          pay_nxt = left_pay;
        end
      end
    end else if (ctl.pull) begin
      valid_nxt = right_valid;
      seq_nxt   = right_seq;
      pay_nxt   = right_pay;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    seq_r <= seq_nxt;
    pay_r <= pay_nxt;
  end

  assign valid_o = valid_r;
  assign seq_o   = seq_r;
  assign pay_o   = pay_r;

endmodule

`default_nettype wire

>>> src/sequence_reorder_buffer_unit.sv
// An accepted item's result is registered into the output register in the next cycle.
// Throughput: 1 item per cycle; every cell compares and shifts in the same cycle.
// Stalls only when the output register is full and out_tready is low.
// Reset (rst_n low, synchronous): buffer empty, capacity 16, no result pending.
// No clearing pass: slot contents are only read behind their valid bits.
// ----------------------------------------------------------------------------
// Sequence reorder buffer
// Sorted insertion buffer built as a row of cells. Inserts land after every
// smaller number; pulls release the head only if it matches the wanted number.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sequence_reorder_buffer_unit_defines.svh"

module sequence_reorder_buffer_unit
  import sru_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              cfg_wen,
  input  wire logic [CAP_W-1:0]  cfg_wdata,   // capacity
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  // [31:0] seq_num, [95:32] payload_in, [127:96] wanted_seq
  input  wire logic [127:0]      in_tdata,
  // [0] req_type
  input  wire logic [0:0]        in_tuser,
  output logic                   out_tvalid,
  input  wire logic              out_tready,
  // [63:0] payload_out, [68:64] fill_count, [69] is_empty,
  // [101:70] highest_seq, [103:102] zero
  output logic [103:0]           out_tdata,
  // [1:0] status
  output logic [1:0]             out_tuser
);

  localparam int PAY_W = PAYLOAD_BYTES * 8;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = CNT_W + CAP_W;   // room for both capacity and count

  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  // ---------------------------------------------------------------- request
  logic             in_acc;
  logic             req;
  logic [SEQ_W-1:0] req_seq, req_want;
  logic [PAY_W-1:0] req_pay;

  assign in_acc   = in_tvalid && in_tready;
  assign req      = in_tuser[0];
  assign req_seq  = in_tdata[31:0];
  assign req_pay  = in_tdata[32 +: PAY_W];   // bytes beyond the payload width dropped
  assign req_want = in_tdata[127:96];

  // ---------------------------------------------------------------- state
  logic [CAP_W-1:0] capacity_r;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [SEQ_W-1:0] highest_r, highest_nxt;

  logic             out_valid_r;
  status_t          out_status_r, out_status_nxt;
  logic [PAY_W-1:0] out_pay_r, out_pay_nxt;
  logic [FILL_W-1:0] out_fill_r;
  logic             out_empty_r;
  logic [SEQ_W-1:0] out_high_r;

  // cell row
  logic [DEPTH-1:0] lt_vec, valid_vec;
  logic [SEQ_W-1:0] seq_arr [DEPTH];
  logic [PAY_W-1:0] pay_arr [DEPTH];
  cell_ctl_t        ctl;

  // ---------------------------------------------------------------- decode
  logic [CMP_W-1:0] cap_ext, eff_cap, cnt_ext;
  logic             is_full, pull_ok, ins_ok;

  assign cap_ext = CMP_W'(capacity_r);
  assign cnt_ext = CMP_W'(count_r);

  // zero acts as one, anything above the row length as the row length
  always_comb begin
    priority if (cap_ext == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > DEPTH_C) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = cap_ext;
    end
  end

  assign is_full = (cnt_ext >= eff_cap) || (cnt_ext >= DEPTH_C);
  assign ins_ok  = in_acc && (req == REQ_INSERT) && !is_full;
  assign pull_ok = in_acc && (req == REQ_PULL) && (count_r != '0) && (seq_arr[0] == req_want);

  assign ctl = '{ins: ins_ok, pull: pull_ok};

  // ---------------------------------------------------------------- cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic             l_lt, l_valid, r_valid;
    logic [SEQ_W-1:0] l_seq, r_seq;
    logic [PAY_W-1:0] l_pay, r_pay;

    if (i == 0) begin : g_head
      // head slot sees an always-valid, always-smaller neighbor: takes the new item
      assign l_lt    = 1'b1;
      assign l_valid = 1'b1;
      assign l_seq   = '0;
      assign l_pay   = '0;
    end else begin : g_left
      assign l_lt    = lt_vec[i-1];
      assign l_valid = valid_vec[i-1];
      assign l_seq   = seq_arr[i-1];
      assign l_pay   = pay_arr[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign r_valid = 1'b0;
      assign r_seq   = '0;
      assign r_pay   = '0;
    end else begin : g_right
      assign r_valid = valid_vec[i+1];
      assign r_seq   = seq_arr[i+1];
      assign r_pay   = pay_arr[i+1];
    end

    sru_cell #(
      .PAY_W (PAY_W)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .new_seq     (req_seq),
      .new_pay     (req_pay),
      .left_lt     (l_lt),
      .left_valid  (l_valid),
      .left_seq    (l_seq),
      .left_pay    (l_pay),
      .right_valid (r_valid),
      .right_seq   (r_seq),
      .right_pay   (r_pay),
      .lt_o        (lt_vec[i]),
      .valid_o     (valid_vec[i]),
      .seq_o       (seq_arr[i]),
      .pay_o       (pay_arr[i])
    );
  end

  // ---------------------------------------------------------------- bookkeeping
  // Highest number tracked on the side: an insert can only raise it (equal
  // numbers go in front), a pull leaves it unless the buffer drains.
  always_comb begin
    count_nxt      = count_r;
    highest_nxt    = highest_r;
    out_status_nxt = ST_DONE;
    out_pay_nxt    = '0;
    if (req == REQ_INSERT) begin
      if (is_full) begin
        out_status_nxt = ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        if ((count_r == '0) || (req_seq > highest_r)) begin
          highest_nxt = req_seq;
        end
      end
    end else begin
      if ((count_r == '0) || (seq_arr[0] != req_want)) begin
        out_status_nxt = ST_NOT_READY;
      end else begin
        out_pay_nxt = pay_arr[0];
        count_nxt   = count_r - CNT_W'(1);
        if (count_nxt == '0) begin
          highest_nxt = '0;
        end
      end
    end
  end

  // output register frees as soon as its result is taken
  assign in_tready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      capacity_r  <= CAP_RESET;
      count_r     <= '0;
      highest_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wen) begin
        capacity_r <= cfg_wdata;
      end
      if (in_acc) begin
        count_r     <= count_nxt;
        highest_r   <= highest_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_status_r <= out_status_nxt;
      out_pay_r    <= out_pay_nxt;
      out_fill_r   <= FILL_W'(count_nxt);
      out_empty_r  <= (count_nxt == '0);
      out_high_r   <= highest_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {2'b00, out_high_r, out_empty_r, out_fill_r, PORT_PW'(out_pay_r)};

  // ---------------------------------------------------------------- checks
  `SRU_ASSERT(a_count_bound, CMP_W'(count_r) <= DEPTH_C, "fill count beyond depth")
  `SRU_ASSERT(a_valid_fill, $countones(valid_vec) == int'(count_r), "valid bits disagree with count")
  `SRU_ASSERT_NEXT(a_pull_dec, pull_ok, count_r == $past(count_r) - CNT_W'(1), "pull did not drop count")
  `SRU_ASSERT_IMPL(a_fail_zero, out_valid_r && (out_status_r != ST_DONE), out_pay_r == '0, "failed request carries payload")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sequence reorder buffer testbench
// Drives insert and pull items through the stream ports with random gaps and
// output stalls, and checks every result against a sorted-list predictor or a typed row's own result.
// A short table of hand-picked items runs first, then random phases at
// several capacities.
// ----------------------------------------------------------------------------
module testbench;
  import sru_pkg::*;

  localparam int BUF_DEPTH  = DEPTH_DEF;
  localparam int PLAN_ROWS  = 25;
  localparam int PHASES     = 8;
  localparam int PHASE_ITEMS = 60;
  localparam int LIMIT      = 200000;

  // one result as the block reports it
  typedef struct packed {
    status_t           status;
    logic [63:0]       payload;
    logic [FILL_W-1:0] fill;
    logic              empty;
    logic [SEQ_W-1:0]  highest;
  } reorder_result_t;

  typedef enum logic [1:0] {ROW_INSERT, ROW_PULL, ROW_CAP} row_kind_t;

  // cap rows carry the capacity in seq; typed rows carry their own result
  typedef struct packed {
    row_kind_t         kind;
    logic [SEQ_W-1:0]  seq;
    logic [63:0]       pay;
    logic [SEQ_W-1:0]  want;
    logic              typed;
    reorder_result_t   known;
  } plan_row_t;

  localparam reorder_result_t UNTYPED = '0;

  plan_row_t plan [PLAN_ROWS] = '{
    // pull on empty buffer right after reset
    '{ROW_PULL, 32'h0, 64'h0, 32'h0, 1'b1,
      '{ST_NOT_READY, 64'h0, 5'd0, 1'b1, 32'h0}},
    // extremes of seq and payload
    '{ROW_INSERT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1,
      '{ST_DONE, 64'h0, 5'd1, 1'b0, 32'hFFFF_FFFF}},
    '{ROW_INSERT, 32'h0, 64'h0, 32'hFFFF_FFFF, 1'b1,
      '{ST_DONE, 64'h0, 5'd2, 1'b0, 32'hFFFF_FFFF}},
    // head mismatch
    '{ROW_PULL, 32'h0, 64'h0, 32'hFFFF_FFFF, 1'b1,
      '{ST_NOT_READY, 64'h0, 5'd2, 1'b0, 32'hFFFF_FFFF}},
    '{ROW_PULL, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0, 1'b1,
      '{ST_DONE, 64'h0, 5'd1, 1'b0, 32'hFFFF_FFFF}},
    // equal numbers: the later insert goes in front
    '{ROW_INSERT, 32'd5, 64'hA5A5_A5A5_A5A5_A5A5, 32'h0, 1'b0, UNTYPED},
    '{ROW_INSERT, 32'd5, 64'h5A5A_5A5A_5A5A_5A5A, 32'h0, 1'b0, UNTYPED},
    '{ROW_PULL, 32'h0, 64'h0, 32'd5, 1'b0, UNTYPED},
    '{ROW_PULL, 32'h0, 64'h0, 32'd5, 1'b0, UNTYPED},
    '{ROW_PULL, 32'h0, 64'h0, 32'hFFFF_FFFF, 1'b1,
      '{ST_DONE, 64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b1, 32'h0}},
    // capacity 1, then 0 which acts as 1
    '{ROW_CAP, 32'd1, 64'h0, 32'h0, 1'b0, UNTYPED},
    '{ROW_INSERT, 32'd7, 64'h0123_4567_89AB_CDEF, 32'h0, 1'b0, UNTYPED},
    '{ROW_INSERT, 32'd3, 64'h1, 32'h0, 1'b1,
      '{ST_FULL, 64'h0, 5'd1, 1'b0, 32'd7}},
    '{ROW_CAP, 32'd0, 64'h0, 32'h0, 1'b0, UNTYPED},
    '{ROW_INSERT, 32'd2, 64'h2, 32'h0, 1'b1,
      '{ST_FULL, 64'h0, 5'd1, 1'b0, 32'd7}},
    '{ROW_PULL, 32'h0, 64'h0, 32'd7, 1'b0, UNTYPED},
    // capacity lowered below the fill
    '{ROW_CAP, 32'd2, 64'h0, 32'h0, 1'b0, UNTYPED},
    '{ROW_INSERT, 32'd20, 64'hDEAD_BEEF_0000_0020, 32'h0, 1'b0, UNTYPED},
    '{ROW_INSERT, 32'd10, 64'hDEAD_BEEF_0000_0010, 32'h0, 1'b0, UNTYPED},
    '{ROW_CAP, 32'd1, 64'h0, 32'h0, 1'b0, UNTYPED},
    '{ROW_INSERT, 32'd15, 64'h15, 32'h0, 1'b1,
      '{ST_FULL, 64'h0, 5'd2, 1'b0, 32'd20}},
    '{ROW_PULL, 32'h0, 64'h0, 32'd10, 1'b0, UNTYPED},
    '{ROW_PULL, 32'h0, 64'h0, 32'd20, 1'b0, UNTYPED},
    // capacity above the depth acts as the depth
    '{ROW_CAP, 32'd31, 64'h0, 32'h0, 1'b0, UNTYPED},
    '{ROW_INSERT, 32'h8000_0000, 64'h8000_0000_0000_0001, 32'h0, 1'b0, UNTYPED}
  };

  // capacity of each random phase
  int unsigned cap_plan [PHASES] = '{16, 31, 4, 0, 1, 9, 16, 2};

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_wen    = 1'b0;
  logic [CAP_W-1:0]      cfg_wdata  = '0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [127:0]          in_tdata   = '0;
  logic [0:0]            in_tuser   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [103:0]          out_tdata;
  logic [1:0]            out_tuser;

  // predictor state
  logic [SEQ_W-1:0]      held_seq [BUF_DEPTH];
  logic [63:0]           held_pay [BUF_DEPTH];
  int                    held_count = 0;
  logic [CAP_W-1:0]      cap_setting = CAP_RESET;

  reorder_result_t       awaited_results [$];
  int                    errors = 0;
  int                    burst_left = 0;
  int                    cycle_count = 0;

  sequence_reorder_buffer_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT) begin
      $display("[sequence_reorder_buffer_unit] ERROR");
      $finish;
    end
  end

  // Sorted list update for one request; returns the result it gives.
  function automatic reorder_result_t apply_request(input logic req,
                                                    input logic [SEQ_W-1:0] seq,
                                                    input logic [63:0] pay,
                                                    input logic [SEQ_W-1:0] want);
    int limit;
    int pos;
    reorder_result_t res;
    res = '0;
    res.status = ST_DONE;
    if (cap_setting == 0) limit = 1;
    else if (cap_setting > BUF_DEPTH) limit = BUF_DEPTH;
    else limit = cap_setting;
    if (req == REQ_INSERT) begin
      if (held_count >= limit) begin
        res.status = ST_FULL;
      end else begin
        pos = 0;
        // strictly smaller numbers stay ahead, so equal ones fall behind the new entry
        while (pos < held_count && held_seq[pos] < seq) pos++;
        for (int i = held_count; i > pos; i--) begin
          held_seq[i] = held_seq[i-1];
          held_pay[i] = held_pay[i-1];
        end
        held_seq[pos] = seq;
        held_pay[pos] = pay;
        held_count++;
      end
    end else begin
      if (held_count == 0 || held_seq[0] != want) begin
        res.status = ST_NOT_READY;
      end else begin
        res.payload = held_pay[0];
        for (int i = 1; i < held_count; i++) begin
          held_seq[i-1] = held_seq[i];
          held_pay[i-1] = held_pay[i];
        end
        held_count--;
      end
    end
    res.fill    = FILL_W'(held_count);
    res.empty   = (held_count == 0);
    res.highest = (held_count == 0) ? '0 : held_seq[held_count-1];
    return res;
  endfunction

  // Sender gap: mostly none or short, a few long, with gap-free bursts.
  function automatic int pick_gap();
    int r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(99, 0);
    if (r < 3) begin
      burst_left = $urandom_range(60, 20);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(3, 1);
    return $urandom_range(25, 6);
  endfunction

  // Present one item at a falling edge and hold it until accepted.
  task automatic send_item(input logic req, input logic [SEQ_W-1:0] seq,
                           input logic [63:0] pay, input logic [SEQ_W-1:0] want,
                           input logic typed, input reorder_result_t known);
    int gap;
    reorder_result_t fresh;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {want, pay, seq};
    in_tuser  <= req;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    fresh = apply_request(req, seq, pay, want);
    awaited_results.push_back(typed ? known : fresh);
  endtask

  // Capacity writes only with nothing in flight.
  task automatic write_capacity(input logic [CAP_W-1:0] value);
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(negedge clk);
    cfg_wen   <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_wen   <= 1'b0;
    cap_setting = value;
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] got_v);
    if (exp_v !== got_v) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, got_v);
    end
  endtask

  // Result side: compare each accepted item with the oldest expectation.
  always @(posedge clk) begin : check_results
    reorder_result_t oldest;
    if (rst_n && out_tvalid && out_tready) begin
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got tuser %0h tdata %0h",
                 $time, out_tuser, out_tdata);
      end else begin
        oldest = awaited_results.pop_front();
        check_field("status", 64'(oldest.status), 64'(out_tuser));
        check_field("payload_out", oldest.payload, out_tdata[63:0]);
        check_field("fill_count", 64'(oldest.fill), 64'(out_tdata[68:64]));
        check_field("is_empty", 64'(oldest.empty), 64'(out_tdata[69]));
        check_field("highest_seq", 64'(oldest.highest), 64'(out_tdata[101:70]));
      end
    end
  end

  // Receiver pacing: short stalls, some long ones, and stall-free stretches.
  initial begin : sink_pacing
    int stall_left;
    int calm_left;
    int r;
    stall_left = 0;
    calm_left  = 0;
    forever begin
      @(negedge clk);
      if (calm_left > 0) begin
        calm_left--;
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 2) begin
          calm_left = $urandom_range(150, 40);
          out_tready <= 1'b1;
        end else if (r < 20) begin
          stall_left = $urandom_range(2, 0);
          out_tready <= 1'b0;
        end else if (r < 23) begin
          stall_left = $urandom_range(39, 9);
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
        end
      end
    end
  end

  initial begin : stimulus
    logic              req;
    logic [SEQ_W-1:0]  seq;
    logic [SEQ_W-1:0]  want;
    logic [SEQ_W-1:0]  seq_base;
    logic [63:0]       pay;
    int                r;
    int                ins_pct;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed table
    for (int k = 0; k < PLAN_ROWS; k++) begin
      if (plan[k].kind == ROW_CAP)
        write_capacity(plan[k].seq[CAP_W-1:0]);
      else
        send_item(plan[k].kind == ROW_PULL ? REQ_PULL : REQ_INSERT, plan[k].seq,
                  plan[k].pay, plan[k].want, plan[k].typed, plan[k].known);
    end

    // random phases; even phases lean on inserts to reach full
    for (int ph = 0; ph < PHASES; ph++) begin
      write_capacity(CAP_W'(cap_plan[ph]));
      ins_pct  = (ph % 2 == 0) ? 70 : 35;
      seq_base = $urandom;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        req = ($urandom_range(99, 0) < ins_pct) ? REQ_INSERT : REQ_PULL;
        pay = {$urandom, $urandom};
        r = $urandom_range(99, 0);
        // clustered numbers give ties and ordering work; rest spans the range
        if (r < 45) seq = seq_base + $urandom_range(7, 0);
        else if (r < 85) seq = $urandom;
        else if (r < 92) seq = '0;
        else seq = '1;
        r = $urandom_range(99, 0);
        if (held_count > 0 && r < 75) want = held_seq[0];
        else if (held_count > 0 && r < 85) want = held_seq[0] ^ (32'h1 << $urandom_range(31, 0));
        else want = $urandom;
        send_item(req, seq, pay, want, 1'b0, UNTYPED);
      end
    end

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("[sequence_reorder_buffer_unit] OK");
    else
      $display("[sequence_reorder_buffer_unit] ERROR");
    $finish;
  end

endmodule

>>> sim.f
+incdir+src
src/sru_pkg.sv
src/sru_cell.sv
src/sequence_reorder_buffer_unit.sv
tb/testbench.sv
